[design/circular_deque_top_macros.svh]
// Assertion macros for the deque checker.
`ifndef CIRCULAR_DEQUE_TOP_MACROS_SVH
`define CIRCULAR_DEQUE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define CDQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/cdq_pkg.sv]
// Package: command and status codes, sequencer states and store control for the deque.
`default_nettype none
package cdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int FUNC_W    = 3;
  localparam int DATA_W    = 32;
  localparam int STAT_W    = 2;

  localparam logic [FUNC_W-1:0] FN_DISPLAY    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_DREAD,
    S_DEMIT
  } cdq_state_t;

  typedef struct packed {
    logic we;
    logic re;
  } cdq_mem_ctl_t;

endpackage
`default_nettype wire

[design/cdq_addr.sv]
// Shared ring-position unit: (head + offset) wrapped into the store depth.
`default_nettype none
module cdq_addr #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  wire logic [AW-1:0] head,
  input  wire logic [CW-1:0] offset,
  output logic      [AW-1:0] pos
);

  localparam int SW = CW + 1;

  logic [SW-1:0] sum;

  // head < DEPTH and offset <= DEPTH, so one compare-subtract wraps it
  always_comb begin
    sum = SW'(head) + SW'(offset);
    if (sum >= SW'(DEPTH)) begin
      pos = AW'(sum - SW'(DEPTH));
    end else begin
      pos = AW'(sum);
    end
  end

endmodule
`default_nettype wire

[design/cdq_mem.sv]
// Ring store: one write or one registered read per cycle.
`default_nettype none
module cdq_mem #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF,
  parameter int AW    = 4
) (
  input  wire logic                        clk,
  input  wire cdq_pkg::cdq_mem_ctl_t       ctl,
  input  wire logic [AW-1:0]               addr,
  input  wire logic [cdq_pkg::DATA_W-1:0]  wdata,
  output logic      [cdq_pkg::DATA_W-1:0]  rdata
);

  logic [cdq_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

[design/cdq_seq.sv]
// Command sequencer: decodes a request, drives the store and the ring unit, emits results.
`default_nettype none
module cdq_seq #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF,
  parameter int AW    = 4,
  parameter int CW    = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [cdq_pkg::DATA_W-1:0]  s_tdata,
  input  wire logic [cdq_pkg::FUNC_W-1:0]  s_tuser,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [cdq_pkg::DATA_W-1:0]  m_tdata,
  output logic      [cdq_pkg::STAT_W-1:0]  m_tuser,
  output logic                             m_tlast,
  output cdq_pkg::cdq_mem_ctl_t            mem_ctl,
  output logic      [AW-1:0]               mem_addr,
  output logic      [cdq_pkg::DATA_W-1:0]  mem_wdata,
  input  wire logic [cdq_pkg::DATA_W-1:0]  mem_rdata,
  output logic      [AW-1:0]               ring_head,
  output logic      [CW-1:0]               ring_offset,
  input  wire logic [AW-1:0]               ring_pos
);

  cdq_pkg::cdq_state_t state, state_next;

  logic [cdq_pkg::FUNC_W-1:0] func, func_next;
  logic [cdq_pkg::DATA_W-1:0] value, value_next;
  logic [AW-1:0]              head, head_next;
  logic [CW-1:0]              count, count_next;
  logic [CW-1:0]              idx, idx_next;

  logic                       m_tvalid_next;
  logic [cdq_pkg::DATA_W-1:0] m_tdata_next;
  logic [cdq_pkg::STAT_W-1:0] m_tuser_next;
  logic                       m_tlast_next;

  logic out_free;
  logic is_disp, is_push, is_pop, is_front;
  logic empty, full, disp_last;

  assign out_free  = !m_tvalid || m_tready;
  assign is_disp   = (func == cdq_pkg::FN_DISPLAY);
  assign is_push   = (func == cdq_pkg::FN_PUSH_FRONT) || (func == cdq_pkg::FN_PUSH_BACK);
  assign is_pop    = (func == cdq_pkg::FN_POP_FRONT) || (func == cdq_pkg::FN_POP_BACK);
  assign is_front  = (func == cdq_pkg::FN_PUSH_FRONT) || (func == cdq_pkg::FN_POP_FRONT);
  assign empty     = (count == '0);
  assign full      = (count == CW'(DEPTH));
  assign disp_last = ((idx + CW'(1)) == count);

  assign ring_head = head;
  assign mem_wdata = value;
  assign mem_addr  = ring_pos;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cdq_pkg::S_IDLE: begin
        if (s_tvalid) state_next = cdq_pkg::S_EXEC;
      end
      cdq_pkg::S_EXEC: begin
        priority if (!is_disp && !is_push && !is_pop) begin
          state_next = cdq_pkg::S_IDLE;
        end else if (is_disp && !empty) begin
          state_next = cdq_pkg::S_DREAD;
        end else if (is_pop && !empty) begin
          state_next = cdq_pkg::S_POP;
        end else if (out_free) begin
          state_next = cdq_pkg::S_IDLE;
        end
      end
      cdq_pkg::S_POP: begin
        if (out_free) state_next = cdq_pkg::S_IDLE;
      end
      cdq_pkg::S_DREAD: begin
        state_next = cdq_pkg::S_DEMIT;
      end
      cdq_pkg::S_DEMIT: begin
        if (out_free) state_next = disp_last ? cdq_pkg::S_IDLE : cdq_pkg::S_DREAD;
      end
      default: state_next = cdq_pkg::S_IDLE;
    endcase
  end

  // datapath control and result generation
  always_comb begin
    s_tready      = 1'b0;
    func_next     = func;
    value_next    = value;
    head_next     = head;
    count_next    = count;
    idx_next      = idx;
    mem_ctl       = '{we: 1'b0, re: 1'b0};
    ring_offset   = idx;
    m_tvalid_next = m_tvalid && !m_tready;
    m_tdata_next  = m_tdata;
    m_tuser_next  = m_tuser;
    m_tlast_next  = m_tlast;
    unique case (state)
      cdq_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          func_next  = s_tuser;
          value_next = s_tdata;
        end
      end
      cdq_pkg::S_EXEC: begin
        priority if (func == cdq_pkg::FN_PUSH_FRONT) begin
          ring_offset = CW'(DEPTH - 1);
        end else if (func == cdq_pkg::FN_PUSH_BACK) begin
          ring_offset = count;
        end else if (func == cdq_pkg::FN_POP_BACK) begin
          ring_offset = count - CW'(1);
        end else begin
          ring_offset = '0;
        end
        priority if (!is_disp && !is_push && !is_pop) begin
          // unused selector: dropped silently
        end else if (is_disp && !empty) begin
          idx_next = '0;
        end else if (is_pop && !empty) begin
          mem_ctl.re = 1'b1;
        end else if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = '0;
          m_tlast_next  = 1'b1;
          priority if (!is_push) begin
            m_tuser_next = cdq_pkg::ST_EMPTY;
          end else if (full) begin
            m_tuser_next = cdq_pkg::ST_FULL;
          end else begin
            m_tuser_next = cdq_pkg::ST_OK;
            mem_ctl.we   = 1'b1;
            count_next   = count + CW'(1);
            if (is_front) head_next = ring_pos;
          end
        end
      end
      cdq_pkg::S_POP: begin
        ring_offset = CW'(1);
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = mem_rdata;
          m_tuser_next  = cdq_pkg::ST_OK;
          m_tlast_next  = 1'b1;
          count_next    = count - CW'(1);
          if (is_front) head_next = ring_pos;
        end
      end
      cdq_pkg::S_DREAD: begin
        mem_ctl.re = 1'b1;
      end
      cdq_pkg::S_DEMIT: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = mem_rdata;
          m_tuser_next  = cdq_pkg::ST_OK;
          m_tlast_next  = disp_last;
          idx_next      = idx + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= cdq_pkg::S_IDLE;
      head     <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      count    <= count_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    func    <= func_next;
    value   <= value_next;
    idx     <= idx_next;
    m_tdata <= m_tdata_next;
    m_tuser <= m_tuser_next;
    m_tlast <= m_tlast_next;
  end

endmodule
`default_nettype wire

[design/circular_deque_top.sv]
// Top level of the bounded double-ended queue of signed 32-bit values.
//
// Deque of up to DEPTH signed 32-bit values in a ring store. A request (func in
// s_tuser, value in s_tdata) is taken only while the sequencer is idle. Push
// requests and empty/full responses go through accept and execute; a pop goes
// through accept, store read and result; a display goes through accept, execute
// and, for every element, one registered read of the single-port store and one
// hand-over of the result, all addressed through one shared ring-position
// adder. A result waiting on m_tready stalls the sequencer, but the next request
// is still taken while it waits. Codes in func other than 0..4 are dropped with
// no result. No clearing pass runs after reset; only occupied entries are read.
`default_nettype none
module circular_deque_top #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [cdq_pkg::DATA_W-1:0]  s_tdata,   // [31:0] value_in
  input  wire logic [cdq_pkg::FUNC_W-1:0]  s_tuser,   // [2:0] func
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [cdq_pkg::DATA_W-1:0]  m_tdata,   // [31:0] value_out
  output logic      [cdq_pkg::STAT_W-1:0]  m_tuser,   // [1:0] status
  output logic                             m_tlast
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cdq_pkg::cdq_mem_ctl_t      mem_ctl;
  logic [AW-1:0]              mem_addr;
  logic [cdq_pkg::DATA_W-1:0] mem_wdata;
  logic [cdq_pkg::DATA_W-1:0] mem_rdata;
  logic [AW-1:0]              ring_head;
  logic [CW-1:0]              ring_offset;
  logic [AW-1:0]              ring_pos;

  cdq_addr #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_addr (
    .head   (ring_head),
    .offset (ring_offset),
    .pos    (ring_pos)
  );

  cdq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  cdq_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .mem_ctl     (mem_ctl),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .mem_rdata   (mem_rdata),
    .ring_head   (ring_head),
    .ring_offset (ring_offset),
    .ring_pos    (ring_pos)
  );

endmodule
`default_nettype wire

[design/cdq_checker.sv]
// Port-level checker for the deque, bound to the top level.
`default_nettype none
`include "circular_deque_top_macros.svh"
module cdq_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_tvalid,
  input wire logic                        s_tready,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [cdq_pkg::DATA_W-1:0]  m_tdata,
  input wire logic [cdq_pkg::STAT_W-1:0]  m_tuser,
  input wire logic                        m_tlast
);

  `CDQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `CDQ_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")
  // empty and full responses are single results with no data
  `CDQ_ASSERT_NOW(a_err_single, m_tvalid && (m_tuser != cdq_pkg::ST_OK), m_tlast && (m_tdata == '0), "error result not last or carries data")
  // one request at a time
  `CDQ_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "request taken while busy")

endmodule

bind circular_deque_top cdq_checker u_cdq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire

[verif/tb_circular_deque_top.sv]
// Testbench for circular_deque_top: directed and random requests checked against a deque model.
`timescale 1ns / 100ps
module tb_circular_deque_top;
  import cdq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic [STAT_W-1:0] status;
    logic              last;
  } deque_resp_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;   // [31:0] value_in
  logic [FUNC_W-1:0] s_tuser = '0;   // [2:0] func
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;        // [31:0] value_out
  logic [STAT_W-1:0] m_tuser;        // [1:0] status
  logic              m_tlast;

  // deque model state
  logic [DATA_W-1:0] ring_mem [DEPTH];
  int                ring_head = 0;
  int                ring_count = 0;

  deque_resp_t       pending_results [$];
  int                fail_cnt = 0;
  bit                idle_en = 1'b0;

  circular_deque_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void add_result(input logic [DATA_W-1:0] v, input logic [STAT_W-1:0] st,
                                     input logic lst);
    deque_resp_t r;
    r.value  = v;
    r.status = st;
    r.last   = lst;
    pending_results.push_back(r);
  endfunction

  // Update the deque model for one accepted request and queue its results.
  function automatic void deque_apply(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] val);
    int pos;
    case (fn)
      FN_DISPLAY: begin
        if (ring_count == 0) begin
          add_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < ring_count; i++) begin
            add_result(ring_mem[(ring_head + i) % DEPTH], ST_OK, i == ring_count - 1);
          end
        end
      end
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (ring_count >= DEPTH) begin
          add_result('0, ST_FULL, 1'b1);
        end else begin
          if (fn == FN_PUSH_FRONT) begin
            ring_head = (ring_head + DEPTH - 1) % DEPTH;
            ring_mem[ring_head] = val;
          end else begin
            ring_mem[(ring_head + ring_count) % DEPTH] = val;
          end
          ring_count++;
          add_result('0, ST_OK, 1'b1);
        end
      end
      FN_POP_FRONT, FN_POP_BACK: begin
        if (ring_count == 0) begin
          add_result('0, ST_EMPTY, 1'b1);
        end else begin
          if (fn == FN_POP_FRONT) begin
            pos = ring_head;
            ring_head = (ring_head + 1) % DEPTH;
          end else begin
            pos = (ring_head + ring_count - 1) % DEPTH;
          end
          ring_count--;
          add_result(ring_mem[pos], ST_OK, 1'b1);
        end
      end
      default: ;  // unused codes are dropped
    endcase
  endfunction

  // Caller is aligned to a rising edge; returns at the edge where the request is taken.
  task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] val);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    deque_apply(fn, val);
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random back-pressure in bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    deque_resp_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d last=%0b",
                 $time, m_tdata, m_tuser, m_tlast);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== want.value) begin
          $display("%0t: value mismatch expected=%h actual=%h", $time, want.value, m_tdata);
          fail_cnt++;
        end
        if (m_tuser !== want.status) begin
          $display("%0t: status mismatch expected=%0d actual=%0d", $time, want.status, m_tuser);
          fail_cnt++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last mismatch expected=%0b actual=%0b", $time, want.last, m_tlast);
          fail_cnt++;
        end
      end
    end
  end

  task automatic test_empty_queue();
    send_request(FN_DISPLAY, 32'h0);
    send_request(FN_POP_FRONT, 32'h0);
    send_request(FN_POP_BACK, 32'hFFFF_FFFF);
  endtask

  task automatic test_mixed_pushes_pops();
    send_request(FN_PUSH_BACK, 32'h7FFF_FFFF);
    send_request(FN_PUSH_FRONT, 32'h8000_0000);
    send_request(FN_PUSH_BACK, 32'h0000_0000);
    send_request(FN_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(FN_DISPLAY, 32'h0);
    // unused codes must produce nothing
    send_request(3'd5, 32'h1234_5678);
    send_request(3'd6, 32'hFFFF_FFFF);
    send_request(3'd7, 32'h0);
    send_request(FN_POP_FRONT, 32'h0);
    send_request(FN_POP_BACK, 32'h0);
    send_request(FN_DISPLAY, 32'h0);
    send_request(FN_POP_BACK, 32'h0);
    send_request(FN_POP_FRONT, 32'h0);
    send_request(FN_POP_FRONT, 32'h0);
  endtask

  // Fill to capacity, push on full, show all, then drain from both ends.
  task automatic test_fill_and_wrap();
    while (ring_count < DEPTH) begin
      send_request($urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK, pick_value());
    end
    send_request(FN_PUSH_FRONT, $urandom);
    send_request(FN_PUSH_BACK, $urandom);
    send_request(FN_DISPLAY, 32'h0);
    while (ring_count > 0) begin
      send_request($urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK, $urandom);
    end
  endtask

  task automatic test_random_traffic(input int n_items);
    int  sent;
    int  r;
    bit  filling;
    sent    = 0;
    filling = 1'b1;
    while (sent < n_items) begin
      if (sent == n_items - 50) idle_en = 1'b0;
      if (ring_count == DEPTH || (ring_count > 10 && $urandom_range(0, 15) == 0)) filling = 1'b0;
      if (ring_count == 0 || (ring_count < 6 && $urandom_range(0, 15) == 0)) filling = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_request(FUNC_W'($urandom_range(5, 7)), $urandom);
      end else begin
        if (r < 12) begin
          send_request(FN_DISPLAY, $urandom);
        end else if (filling ? (r < 75) : (r < 35)) begin
          send_request($urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK, pick_value());
        end else begin
          send_request($urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK, $urandom);
        end
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_en = 1'b1;
    test_empty_queue();
    test_mixed_pushes_pops();
    wait_results_drained();
    test_fill_and_wrap();
    test_random_traffic(245);
    wait_results_drained();
    repeat (50) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
